// ===== design/uia_pkg.sv =====
// Shared types and constants of the unique identifier allocator.
`timescale 1ns / 1ps

package uia_pkg;

  localparam int ID_W      = 8;
  localparam int FRESH_W   = ID_W + 1;
  localparam int MAP_DEPTH = 1 << ID_W;
  localparam int WORD_W    = 16;
  localparam int BIT_IDX_W = $clog2(WORD_W);
  localparam int WORD_CNT  = MAP_DEPTH / WORD_W;
  localparam int WORD_IDX_W = $clog2(WORD_CNT);

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [1:0] STATUS_GRANTED   = 2'd0;
  localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [1:0] STATUS_RELEASED  = 2'd2;
  localparam logic [1:0] STATUS_IGNORED   = 2'd3;

  typedef struct packed {
    logic            command;
    logic [ID_W-1:0] number;
  } in_beat_t;

  typedef struct packed {
    logic [ID_W-1:0] number_res;
    logic [1:0]      status;
  } out_beat_t;

  typedef struct packed {
    logic            set_en;
    logic            clr_en;
    logic [ID_W-1:0] addr;
  } map_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN_SUM,
    ST_SCAN_WORD,
    ST_RELEASE
  } state_t;

endpackage

// ===== design/uia_lsb_find.sv =====
// Shared lowest-set-bit finder used for both the summary and the map words.
`timescale 1ns / 1ps

module uia_lsb_find (
  input  logic [uia_pkg::WORD_W-1:0]    vec,
  output logic                          found,
  output logic [uia_pkg::BIT_IDX_W-1:0] idx
);

  always_comb begin
    found = |vec;
    idx   = '0;
    for (int i = uia_pkg::WORD_W - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = uia_pkg::BIT_IDX_W'(i);
      end
    end
  end

endmodule

// ===== design/uia_free_map.sv =====
// Free map storage as words with a summary of the words that hold a free bit.
`timescale 1ns / 1ps

module uia_free_map (
  input  logic                            clk,
  input  logic                            rst_n,
  input  uia_pkg::map_ctrl_t              ctrl,
  input  logic [uia_pkg::WORD_IDX_W-1:0]  rd_word,
  output logic [uia_pkg::WORD_W-1:0]      rd_data,
  output logic [uia_pkg::WORD_CNT-1:0]    summary
);

  logic [uia_pkg::WORD_W-1:0]     words_r [uia_pkg::WORD_CNT];
  logic [uia_pkg::WORD_CNT-1:0]   summary_r;
  logic [uia_pkg::WORD_IDX_W-1:0] wr_word;
  logic [uia_pkg::WORD_W-1:0]     bit_mask;
  logic [uia_pkg::WORD_W-1:0]     cur_word;

  assign wr_word  = ctrl.addr[uia_pkg::ID_W-1:uia_pkg::BIT_IDX_W];
  assign bit_mask = uia_pkg::WORD_W'(1) << ctrl.addr[uia_pkg::BIT_IDX_W-1:0];
  assign cur_word = words_r[wr_word];
  assign rd_data  = words_r[rd_word];
  assign summary  = summary_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < uia_pkg::WORD_CNT; i++) begin
        words_r[i] <= '0;
      end
      summary_r <= '0;
    end else if (ctrl.set_en) begin
      words_r[wr_word]   <= cur_word | bit_mask;
      summary_r[wr_word] <= 1'b1;
    end else if (ctrl.clr_en) begin
      words_r[wr_word]   <= cur_word & ~bit_mask;
      summary_r[wr_word] <= |(cur_word & ~bit_mask);
    end
  end

endmodule

// ===== design/unique_id_allocator.sv =====
// Top level of the unique identifier allocator with its command sequencer.
// An allocate reusing a released identifier scans the summary, then a word;
// a fresh grant or exhausted pool ends after the summary scan. A release uses
// its own state; busy is high from accept until the result cycle.
// One shared 16-bit lowest-set-bit finder scans the summary, then one word.
// Synchronous reset clears the free map and the high-water counter at once.
`timescale 1ns / 1ps

module unique_id_allocator #(
  parameter int ID_COUNT = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  uia_pkg::in_beat_t   in_beat,
  output logic                out_valid,
  output uia_pkg::out_beat_t  out_beat
);

  localparam int POOL_INT = (ID_COUNT < uia_pkg::MAP_DEPTH) ? ID_COUNT : uia_pkg::MAP_DEPTH;
  localparam logic [uia_pkg::FRESH_W-1:0] POOL_LIMIT = uia_pkg::FRESH_W'(POOL_INT);

  uia_pkg::state_t                 state_r, state_nxt;
  uia_pkg::in_beat_t               req_r, req_nxt;
  logic [uia_pkg::WORD_IDX_W-1:0]  word_idx_r, word_idx_nxt;
  logic [uia_pkg::FRESH_W-1:0]     fresh_r, fresh_nxt;
  uia_pkg::out_beat_t              out_r, out_nxt;
  logic                            out_valid_r, out_valid_nxt;

  uia_pkg::map_ctrl_t              map_ctrl;
  logic [uia_pkg::WORD_W-1:0]      map_word;
  logic [uia_pkg::WORD_CNT-1:0]    map_summary;
  logic [uia_pkg::WORD_W-1:0]      lsb_vec;
  logic                            lsb_found;
  logic [uia_pkg::BIT_IDX_W-1:0]   lsb_idx;

  uia_free_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (map_ctrl),
    .rd_word (word_idx_r),
    .rd_data (map_word),
    .summary (map_summary)
  );

  uia_lsb_find u_find (
    .vec   (lsb_vec),
    .found (lsb_found),
    .idx   (lsb_idx)
  );

  assign busy      = (state_r != uia_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      uia_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = (in_beat.command == uia_pkg::CMD_RELEASE) ?
                      uia_pkg::ST_RELEASE : uia_pkg::ST_SCAN_SUM;
        end
      end
      uia_pkg::ST_SCAN_SUM: begin
        state_nxt = lsb_found ? uia_pkg::ST_SCAN_WORD : uia_pkg::ST_IDLE;
      end
      uia_pkg::ST_SCAN_WORD: state_nxt = uia_pkg::ST_IDLE;
      uia_pkg::ST_RELEASE:   state_nxt = uia_pkg::ST_IDLE;
      default:               state_nxt = uia_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_nxt       = req_r;
    word_idx_nxt  = word_idx_r;
    fresh_nxt     = fresh_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    map_ctrl      = '0;
    lsb_vec       = map_summary;
    case (state_r)
      uia_pkg::ST_IDLE: begin
        if (start) begin
          req_nxt = in_beat;
        end
      end
      uia_pkg::ST_SCAN_SUM: begin
        lsb_vec      = map_summary;
        word_idx_nxt = lsb_idx;
        if (!lsb_found) begin
          out_valid_nxt = 1'b1;
          if (fresh_r >= POOL_LIMIT) begin
            out_nxt.number_res = '0;
            out_nxt.status     = uia_pkg::STATUS_EXHAUSTED;
          end else begin
            out_nxt.number_res = fresh_r[uia_pkg::ID_W-1:0];
            out_nxt.status     = uia_pkg::STATUS_GRANTED;
            fresh_nxt          = fresh_r + uia_pkg::FRESH_W'(1);
          end
        end
      end
      uia_pkg::ST_SCAN_WORD: begin
        lsb_vec            = map_word;
        map_ctrl.clr_en    = 1'b1;
        map_ctrl.addr      = {word_idx_r, lsb_idx};
        out_valid_nxt      = 1'b1;
        out_nxt.number_res = {word_idx_r, lsb_idx};
        out_nxt.status     = uia_pkg::STATUS_GRANTED;
      end
      uia_pkg::ST_RELEASE: begin
        out_valid_nxt      = 1'b1;
        out_nxt.number_res = req_r.number;
        if ({1'b0, req_r.number} < fresh_r) begin
          map_ctrl.set_en = 1'b1;
          map_ctrl.addr   = req_r.number;
          out_nxt.status  = uia_pkg::STATUS_RELEASED;
        end else begin
          out_nxt.status  = uia_pkg::STATUS_IGNORED;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= uia_pkg::ST_IDLE;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    word_idx_r <= word_idx_nxt;
    out_r      <= out_nxt;
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not make the block busy");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r != uia_pkg::ST_IDLE))
    else $error("result strobe without a command in progress");

  a_grant_below_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == uia_pkg::STATUS_GRANTED) |->
    ({1'b0, out_r.number_res} < fresh_r))
    else $error("granted identifier lies at or above the high-water mark");

  a_exhausted_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == uia_pkg::STATUS_EXHAUSTED) |->
    (fresh_r == POOL_LIMIT && map_summary == '0))
    else $error("exhaustion reported while identifiers remain");

endmodule

// ===== bench/unique_id_allocator_tb.sv =====
// Self-checking testbench of the unique identifier allocator.
`timescale 1ns / 1ps

module unique_id_allocator_tb;

  localparam int ID_COUNT    = 256;
  localparam int POOL_SIZE   = (ID_COUNT < uia_pkg::MAP_DEPTH) ? ID_COUNT : uia_pkg::MAP_DEPTH;
  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SHOW_MAX    = 10;

  class id_pool_tracker;
    bit [uia_pkg::MAP_DEPTH-1:0] free_ids;
    bit [uia_pkg::FRESH_W-1:0]   fresh_next;
    uia_pkg::out_beat_t          pending_replies[$];
    int unsigned                 errors;
    int unsigned                 shown;
    int unsigned                 requests;
    int unsigned                 status_seen[4];

    function new();
      free_ids   = '0;
      fresh_next = '0;
      errors     = 0;
      shown      = 0;
      requests   = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void note_request(uia_pkg::in_beat_t req);
      uia_pkg::out_beat_t reply;
      bit                 found;
      reply = '0;
      found = 1'b0;
      if (req.command == uia_pkg::CMD_ALLOC) begin
        for (int i = 0; i < uia_pkg::MAP_DEPTH; i++) begin
          if (!found && free_ids[i]) begin
            found            = 1'b1;
            free_ids[i]      = 1'b0;
            reply.number_res = uia_pkg::ID_W'(i);
            reply.status     = uia_pkg::STATUS_GRANTED;
          end
        end
        if (!found) begin
          if (fresh_next >= POOL_SIZE) begin
            reply.number_res = '0;
            reply.status     = uia_pkg::STATUS_EXHAUSTED;
          end else begin
            reply.number_res = fresh_next[uia_pkg::ID_W-1:0];
            reply.status     = uia_pkg::STATUS_GRANTED;
            fresh_next       = fresh_next + 1'b1;
          end
        end
      end else begin
        reply.number_res = req.number;
        if (req.number < fresh_next) begin
          free_ids[req.number] = 1'b1;
          reply.status         = uia_pkg::STATUS_RELEASED;
        end else begin
          reply.status = uia_pkg::STATUS_IGNORED;
        end
      end
      requests++;
      status_seen[reply.status]++;
      pending_replies.push_back(reply);
    endfunction

    function void check_reply(uia_pkg::out_beat_t got);
      uia_pkg::out_beat_t want;
      if (pending_replies.size() == 0) begin
        errors++;
        if (shown < SHOW_MAX) begin
          shown++;
          $display("ERROR: unexpected result beat number_res=%0d status=%0d",
                   got.number_res, got.status);
        end
        return;
      end
      want = pending_replies.pop_front();
      if (got.number_res !== want.number_res || got.status !== want.status) begin
        errors++;
        if (shown < SHOW_MAX) begin
          shown++;
          $display("ERROR: expected number_res=%0d status=%0d, %s",
                   want.number_res, want.status,
                   $sformatf("got number_res=%0d status=%0d",
                             got.number_res, got.status));
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  uia_pkg::in_beat_t   in_beat = '0;
  logic                out_valid;
  uia_pkg::out_beat_t  out_beat;

  id_pool_tracker tracker;
  int unsigned    gap_max = 12;
  int unsigned    cycle_count = 0;

  unique_id_allocator #(
    .ID_COUNT(ID_COUNT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_beat(in_beat),
    .out_valid(out_valid),
    .out_beat(out_beat)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL unique_id_allocator");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      tracker.check_reply(out_beat);
    end
  end

  task automatic issue(input logic cmd, input logic [uia_pkg::ID_W-1:0] num);
    uia_pkg::in_beat_t req;
    int unsigned       gap;
    req.command = cmd;
    req.number  = num;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_beat <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.note_request(req);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (tracker.pending_replies.size() != 0);
  endtask

  task automatic run_phase(input int unsigned count, input int unsigned alloc_pct,
                           input int unsigned gmax);
    gap_max = gmax;
    repeat (count) begin
      if ($urandom_range(1, 100) <= alloc_pct) begin
        issue(uia_pkg::CMD_ALLOC, uia_pkg::ID_W'($urandom));
      end else if (tracker.fresh_next != 0 && $urandom_range(0, 3) != 0) begin
        issue(uia_pkg::CMD_RELEASE,
              uia_pkg::ID_W'($urandom_range(0, tracker.fresh_next - 1)));
      end else begin
        issue(uia_pkg::CMD_RELEASE, uia_pkg::ID_W'($urandom));
      end
    end
  endtask

  initial begin
    tracker = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gap_max = 12;
    issue(uia_pkg::CMD_ALLOC, 8'h00);
    issue(uia_pkg::CMD_RELEASE, 8'h00);
    issue(uia_pkg::CMD_RELEASE, 8'h00);
    issue(uia_pkg::CMD_RELEASE, 8'hFF);
    issue(uia_pkg::CMD_RELEASE, 8'h01);
    issue(uia_pkg::CMD_ALLOC, 8'hFF);
    issue(uia_pkg::CMD_ALLOC, 8'h55);
    issue(uia_pkg::CMD_ALLOC, 8'hAA);
    issue(uia_pkg::CMD_ALLOC, 8'h00);
    issue(uia_pkg::CMD_RELEASE, 8'h01);
    issue(uia_pkg::CMD_RELEASE, 8'h03);
    issue(uia_pkg::CMD_ALLOC, 8'h00);
    issue(uia_pkg::CMD_ALLOC, 8'h00);
    issue(uia_pkg::CMD_ALLOC, 8'h00);
    issue(uia_pkg::CMD_RELEASE, 8'h80);
    issue(uia_pkg::CMD_RELEASE, 8'h04);
    issue(uia_pkg::CMD_ALLOC, 8'hFF);
    drain();

    // A heavy allocation phase drives the high-water counter to the pool size.
    run_phase(420, 92, 12);
    drain();
    run_phase(300, 40, 0);
    run_phase(350, 60, 12);
    drain();
    run_phase(330, 50, 12);

    drain();
    repeat (SETTLE) @(posedge clk);
    tracker.errors += tracker.pending_replies.size();

    $display("Ran %0d requests: %0d grants, %0d exhausted, %0d releases, %0d ignored.",
             tracker.requests, tracker.status_seen[uia_pkg::STATUS_GRANTED],
             tracker.status_seen[uia_pkg::STATUS_EXHAUSTED],
             tracker.status_seen[uia_pkg::STATUS_RELEASED],
             tracker.status_seen[uia_pkg::STATUS_IGNORED]);
    $display("Mismatched or unexpected beats: %0d.", tracker.errors);
    if (tracker.errors == 0) begin
      $display("PASS unique_id_allocator");
    end else begin
      $display("FAIL unique_id_allocator");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/uia_pkg.sv
design/uia_lsb_find.sv
design/uia_free_map.sv
design/unique_id_allocator.sv
bench/unique_id_allocator_tb.sv
